// ===== rtl/core/sre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types and constants for the SEIR transmission rate estimator core.
// ----------------------------------------------------------------------------
package sre_pkg;

  // fixed field widths
  localparam int VAL_W  = 48;   // compartment, signed Q32.16
  localparam int RATE_W = 17;   // rates, unsigned Q0.17
  localparam int OUT_W  = 64;   // result value
  localparam int MUL_W  = 64;   // multiplier operand width
  localparam int DIG_W  = 16;   // multiplier digit per cycle
  localparam int PROD_W = 128;  // product, numerator and divisor width
  localparam int ITER_W = 8;    // divider iteration count width

  // beta numerator magnitude is below 2^113
  localparam logic [ITER_W-1:0] BETA_ITERS = 8'd113;

  // 1.0 with 17 fraction bits
  localparam logic [RATE_W:0] ONE_Q17 = 18'h20000;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_LATENT_RATE    = 3'd0;
  localparam logic [2:0] REG_RECOVERY_RATE  = 3'd1;
  localparam logic [2:0] REG_IMMUNITY_RATE  = 3'd2;
  localparam logic [2:0] REG_LATENT_STAGES  = 3'd3;
  localparam logic [2:0] REG_INFECT_STAGES  = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_MULA_GO,
    ST_MULA_WAIT,
    ST_DIV_WAIT,
    ST_MULH_WAIT,
    ST_BMUL_WAIT,
    ST_BDIV_WAIT,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_BETA_OUT
  } state_t;

endpackage

// ===== rtl/core/seir_transmission_rate_estimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seir_transmission_rate_estimator_core
// Trapezoidal SEIR chain stepper that rebuilds the transmission rate beta.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall): operation 0 loads one initial
//   compartment column, operation 1 advances one time step. Loads produce
//   nothing. Configure rates and stage counts through the cfg_write port
//   while the core is idle.
//   Result channel (result_valid / result_stall): the first step returns the
//   initial row (m+n+2 transfers); each later step returns the new row and
//   then beta of the previous row, with last on the final transfer.
//   Work: each stage column costs a memory read, a multiply, a divide
//   and a second multiply. One item is in work at a time; item_stall is
//   high until the last result is in the output register.
//   Reset clears configuration, the started flag and the history, but not
//   the compartment memory, which must be loaded before the first step.
//   A stalled result holds in the output register and the sequencer waits.
// ----------------------------------------------------------------------------
module seir_transmission_rate_estimator_core #(
  parameter int MAX_LATENT     = 8,
  parameter int MAX_INFECTIOUS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_write,
  input  logic [2:0]                         cfg_index,
  input  logic [sre_pkg::RATE_W-1:0]         cfg_data,
  // items
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic                               operation,
  input  logic [4:0]                         init_index,
  input  logic signed [sre_pkg::VAL_W-1:0]   init_value,
  input  logic signed [sre_pkg::VAL_W-1:0]   incidence,
  input  logic signed [sre_pkg::VAL_W-1:0]   births,
  input  logic [sre_pkg::RATE_W-1:0]         death_rate,
  // results
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [4:0]                         column,
  output logic signed [sre_pkg::OUT_W-1:0]   value,
  output logic                               divide_error,
  output logic                               last
);
  import sre_pkg::*;

  localparam int NCOMP  = MAX_LATENT + MAX_INFECTIOUS + 2;
  localparam int ADDR_W = $clog2(NCOMP);
  localparam int COL_W  = $clog2(NCOMP + 1);
  localparam int MC_W   = $clog2(MAX_LATENT + 1);
  localparam int NC_W   = $clog2(MAX_INFECTIOUS + 1);
  localparam int CNT_W  = (MC_W > NC_W) ? MC_W : NC_W;
  localparam int H_W    = RATE_W + CNT_W;
  localparam int ISUM_W = VAL_W + NC_W;
  localparam logic [ITER_W-1:0] STG_ITERS = ITER_W'(H_W + 50);

  // saturate a quotient magnitude to signed 48 bits
  function automatic logic [VAL_W-1:0] sat48(input logic [PROD_W-1:0] q, input logic n);
    if (!n) return (q > PROD_W'(48'h7FFF_FFFF_FFFF)) ? 48'h7FFF_FFFF_FFFF : q[VAL_W-1:0];
    return (q > PROD_W'(48'h8000_0000_0000)) ? 48'h8000_0000_0000
                                             : (VAL_W'(0) - q[VAL_W-1:0]);
  endfunction

  // saturate a quotient magnitude to signed 64 bits
  function automatic logic [OUT_W-1:0] sat64(input logic [PROD_W-1:0] q, input logic n);
    if (!n) return (q > PROD_W'(64'h7FFF_FFFF_FFFF_FFFF)) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                          : q[OUT_W-1:0];
    return (q > PROD_W'(64'h8000_0000_0000_0000)) ? 64'h8000_0000_0000_0000
                                                  : (OUT_W'(0) - q[OUT_W-1:0]);
  endfunction

  // configuration registers
  logic [RATE_W-1:0] latent_rate;
  logic [RATE_W-1:0] recovery_rate;
  logic [RATE_W-1:0] immunity_loss_rate;
  logic [3:0]        latent_stages;
  logic [3:0]        infectious_stages;

  // history and control
  state_t            state, state_next;
  logic              started;
  logic [VAL_W-1:0]  prev_z;
  logic [RATE_W-1:0] prev_mu;
  logic [COL_W-1:0]  col;
  logic              with_beta;

  // step payload
  logic [RATE_W:0]   w0, w1;
  logic [VAL_W-1:0]  zt, bt;
  logic [VAL_W:0]    zsum;
  logic [PROD_W-1:0] carry;
  logic [VAL_W-1:0]  xs;
  logic [VAL_W-1:0]  sold;
  logic [ISUM_W-1:0] infsum;
  logic [OUT_W-1:0]  beta;
  logic              berr;

  // memory
  logic [VAL_W-1:0]  mem [NCOMP];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic [VAL_W-1:0]  rdata;

  // arithmetic units
  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              div_start, div_done, div_neg;
  logic [PROD_W-1:0] div_num, div_den, div_q;
  logic [ITER_W-1:0] div_iters;

  // misc combinational
  logic              acc_item, slot_free, out_load;
  logic [MC_W-1:0]   m_cnt;
  logic [NC_W-1:0]   n_cnt;
  logic [COL_W-1:0]  m_col, rm_col;
  logic              is_lat, is_inf;
  logic [H_W-1:0]    h_cur;
  logic [VAL_W-1:0]  xt;
  logic [PROD_W-1:0] bz_shift, numer, bden;

  // stage counts and column classes
  assign m_cnt  = (int'(latent_stages) > MAX_LATENT) ? MC_W'(MAX_LATENT)
                                                     : MC_W'(latent_stages);
  assign n_cnt  = (int'(infectious_stages) > MAX_INFECTIOUS) ? NC_W'(MAX_INFECTIOUS)
                                                             : NC_W'(infectious_stages);
  assign m_col  = COL_W'(m_cnt);
  assign rm_col = COL_W'(m_cnt) + COL_W'(n_cnt) + COL_W'(1);
  assign is_lat = (col != '0) && (col <= m_col);
  assign is_inf = (col > m_col) && (col < rm_col);

  // step size h of the current column
  always_comb begin
    if (is_lat)             h_cur = H_W'(latent_rate) * H_W'(m_cnt);
    else if (is_inf)        h_cur = H_W'(recovery_rate) * H_W'(n_cnt);
    else if (col == rm_col) h_cur = H_W'(immunity_loss_rate);
    else                    h_cur = '0;
  end

  assign xt       = sat48(div_q, div_neg);
  assign bz_shift = ({{(PROD_W-VAL_W){bt[VAL_W-1]}}, bt}
                   - {{(PROD_W-VAL_W){zt[VAL_W-1]}}, zt}) << 17;
  assign numer    = {{(PROD_W-OUT_W-VAL_W-1){zsum[VAL_W]}}, zsum, {OUT_W{1'b0}}};
  assign bden     = {mul_prod[PROD_W-2:0], 1'b0};

  assign item_stall = (state != ST_IDLE);
  assign acc_item   = item_valid && !item_stall;
  assign slot_free  = !result_valid || !result_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      latent_rate        <= '0;
      recovery_rate      <= '0;
      immunity_loss_rate <= '0;
      latent_stages      <= 4'd1;
      infectious_stages  <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LATENT_RATE:   latent_rate        <= cfg_data;
        REG_RECOVERY_RATE: recovery_rate      <= cfg_data;
        REG_IMMUNITY_RATE: immunity_loss_rate <= cfg_data;
        REG_LATENT_STAGES: latent_stages      <= cfg_data[3:0];
        REG_INFECT_STAGES: infectious_stages  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // compartment memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[col[ADDR_W-1:0]];
  end

  // arithmetic units
  sre_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod),
    .done (mul_done)
  );

  sre_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .iters(div_iters),
    .quot (div_q),
    .neg  (div_neg),
    .done (div_done)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state and unit controls
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    div_iters  = STG_ITERS;
    mem_we     = 1'b0;
    mem_waddr  = ADDR_W'(init_index);
    mem_wdata  = init_value;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (acc_item) begin
          if (operation == OP_LOAD) begin
            mem_we = (int'(init_index) < NCOMP);
          end else begin
            state_next = started ? ST_RD : ST_EMIT_RD;
          end
        end
      end
      ST_RD: begin
        mem_re     = 1'b1;
        state_next = ST_MULA_GO;
      end
      ST_MULA_GO: begin
        mul_start  = 1'b1;
        mul_a      = {{(MUL_W-RATE_W-1){1'b0}}, w0} - {{(MUL_W-H_W){1'b0}}, h_cur};
        mul_b      = {{(MUL_W-VAL_W){rdata[VAL_W-1]}}, rdata};
        state_next = ST_MULA_WAIT;
      end
      ST_MULA_WAIT: begin
        div_num = mul_prod + carry;
        div_den = {{(PROD_W-RATE_W-1){1'b0}}, w1} + {{(PROD_W-H_W){1'b0}}, h_cur};
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        mul_a     = {{(MUL_W-H_W){1'b0}}, h_cur};
        mul_b     = {{(MUL_W-VAL_W){xs[VAL_W-1]}}, xs} + {{(MUL_W-VAL_W){xt[VAL_W-1]}}, xt};
        mem_waddr = col[ADDR_W-1:0];
        mem_wdata = xt;
        if (div_done) begin
          mem_we     = 1'b1;
          mul_start  = 1'b1;
          state_next = ST_MULH_WAIT;
        end
      end
      ST_MULH_WAIT: begin
        mul_a = {{(MUL_W-VAL_W){sold[VAL_W-1]}}, sold};
        mul_b = {{(MUL_W-ISUM_W){infsum[ISUM_W-1]}}, infsum};
        if (mul_done) begin
          if (col == '0) begin
            mul_start  = 1'b1;
            state_next = ST_BMUL_WAIT;
          end else begin
            state_next = ST_RD;
          end
        end
      end
      ST_BMUL_WAIT: begin
        div_num   = numer;
        div_den   = bden;
        div_iters = BETA_ITERS;
        if (mul_done) begin
          if (bden == '0) begin
            state_next = ST_EMIT_RD;
          end else begin
            div_start  = 1'b1;
            state_next = ST_BDIV_WAIT;
          end
        end
      end
      ST_BDIV_WAIT: begin
        if (div_done) state_next = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        mem_re     = 1'b1;
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (col == rm_col) state_next = with_beta ? ST_BETA_OUT : ST_IDLE;
          else               state_next = ST_EMIT_RD;
        end
      end
      ST_BETA_OUT: begin
        if (slot_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // history registers
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      prev_z  <= '0;
      prev_mu <= '0;
    end else if (acc_item && operation == OP_STEP) begin
      started <= 1'b1;
      prev_z  <= incidence;
      prev_mu <= death_rate;
    end
  end

  // step datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (acc_item && operation == OP_STEP) begin
          zt        <= incidence;
          bt        <= births;
          w0        <= ONE_Q17 - {1'b0, prev_mu};
          w1        <= ONE_Q17 + {1'b0, death_rate};
          zsum      <= {prev_z[VAL_W-1], prev_z} + {incidence[VAL_W-1], incidence};
          carry     <= {{(PROD_W-VAL_W-17){incidence[VAL_W-1]}}, incidence, 17'b0};
          infsum    <= '0;
          with_beta <= started;
          col       <= started ? COL_W'(1) : COL_W'(0);
        end
      end
      ST_MULA_GO: begin
        xs <= rdata;
        if (is_inf) infsum <= infsum + {{(ISUM_W-VAL_W){rdata[VAL_W-1]}}, rdata};
        if (col == '0) sold <= rdata;
      end
      ST_MULH_WAIT: begin
        if (mul_done) begin
          carry <= mul_prod + ((col == rm_col) ? bz_shift : PROD_W'(0));
          if (col == rm_col)   col <= '0;
          else if (col != '0)  col <= col + COL_W'(1);
        end
      end
      ST_BMUL_WAIT: begin
        if (mul_done && bden == '0) begin
          berr <= 1'b1;
          beta <= zsum[VAL_W] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
      end
      ST_BDIV_WAIT: begin
        if (div_done) begin
          berr <= 1'b0;
          beta <= sat64(div_q, div_neg);
        end
      end
      ST_EMIT_WAIT: begin
        if (slot_free && col != rm_col) col <= col + COL_W'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_BETA_OUT) begin
        column       <= 5'(rm_col + COL_W'(1));
        value        <= beta;
        divide_error <= berr;
        last         <= 1'b1;
      end else begin
        column       <= 5'(col);
        value        <= {{(OUT_W-VAL_W){rdata[VAL_W-1]}}, rdata};
        divide_error <= 1'b0;
        last         <= !with_beta && (col == rm_col);
      end
    end
  end

  // checks
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!result_valid || !result_stall))
    else $error("output register overwritten while stalled");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (int'(mem_waddr) < NCOMP))
    else $error("compartment write beyond memory");

endmodule

// ===== rtl/core/sre_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_mul
// Signed 64 x 64 multiplier, one 16-bit digit of the second operand per
// cycle, sign applied in a final step.
// ----------------------------------------------------------------------------
module sre_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [sre_pkg::MUL_W-1:0] a,
  input  logic signed [sre_pkg::MUL_W-1:0] b,
  output logic        [sre_pkg::PROD_W-1:0] prod,
  output logic                             done
);
  import sre_pkg::*;

  localparam int NDIG = MUL_W / DIG_W;
  localparam int PW   = MUL_W + DIG_W;

  logic [2:0]        ph;
  logic [MUL_W-1:0]  amag;
  logic [MUL_W-1:0]  bmag;
  logic              neg;
  logic [PROD_W-1:0] acc;
  logic [PW-1:0]     part;

  // partial product of the top digit
  assign part = {{DIG_W{1'b0}}, amag} * {{MUL_W{1'b0}}, bmag[MUL_W-1 -: DIG_W]};

  // phase control
  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ph <= 3'd1;
      end else if (ph != 3'd0 && ph <= 3'(NDIG)) begin
        ph <= ph + 3'd1;
      end else if (ph == 3'(NDIG + 1)) begin
        ph   <= '0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      amag <= a[MUL_W-1] ? (MUL_W'(0) - a) : a;
      bmag <= b[MUL_W-1] ? (MUL_W'(0) - b) : b;
      neg  <= a[MUL_W-1] ^ b[MUL_W-1];
      acc  <= '0;
    end else if (ph != 3'd0 && ph <= 3'(NDIG)) begin
      acc  <= (acc << DIG_W) + PROD_W'(part);
      bmag <= bmag << DIG_W;
    end else if (ph == 3'(NDIG + 1)) begin
      prod <= neg ? (PROD_W'(0) - acc) : acc;
    end
  end

endmodule

// ===== rtl/core/sre_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sre_div
// Restoring divider, one quotient bit per cycle. Returns the quotient
// magnitude and its sign; the caller truncates and saturates.
// ----------------------------------------------------------------------------
module sre_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [sre_pkg::PROD_W-1:0] num,
  input  logic signed [sre_pkg::PROD_W-1:0] den,
  input  logic        [sre_pkg::ITER_W-1:0] iters,
  output logic        [sre_pkg::PROD_W-1:0] quot,
  output logic                              neg,
  output logic                              done
);
  import sre_pkg::*;

  logic [ITER_W-1:0] cnt;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] nreg;
  logic [PROD_W-1:0] dmag;
  logic [PROD_W-1:0] nmag;
  logic [PROD_W-1:0] r2;
  logic              ge;

  assign nmag = num[PROD_W-1] ? (PROD_W'(0) - num) : num;
  assign r2   = {rem[PROD_W-2:0], nreg[PROD_W-1]};
  assign ge   = (r2 >= dmag);

  // iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= iters;
      end else if (cnt != '0) begin
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) done <= 1'b1;
      end
    end
  end

  // shift, compare, subtract
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= num[PROD_W-1] ^ den[PROD_W-1];
      dmag <= den[PROD_W-1] ? (PROD_W'(0) - den) : den;
      nreg <= nmag << (ITER_W'(PROD_W) - iters);
      rem  <= '0;
      quot <= '0;
    end else if (cnt != '0) begin
      rem  <= ge ? (r2 - dmag) : r2;
      quot <= {quot[PROD_W-2:0], ge};
      nreg <= nreg << 1;
    end
  end

endmodule
